// ===== hdl/jq_pkg.sv =====
package jq_pkg;

   localparam int unsigned QueueDepthDefault = 16;
   localparam int unsigned JobWidth = 16;
   localparam int unsigned PidWidth = 22;
   localparam int unsigned SlotWidth = JobWidth + PidWidth;
   localparam int unsigned FieldPosWidth = 5;

   typedef enum logic [2:0] {
      REQ_INSERT   = 3'd0,
      REQ_POP      = 3'd1,
      REQ_RM_JOB   = 3'd2,
      REQ_RM_PID   = 3'd3,
      REQ_FIND_JOB = 3'd4,
      REQ_FIND_PID = 3'd5,
      REQ_RSVD6    = 3'd6,
      REQ_RSVD7    = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [JobWidth-1:0] job_number;
      logic [PidWidth-1:0] proc_id;
   } req_type_s_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [JobWidth-1:0]      out_job_number;
      logic [PidWidth-1:0]      out_proc_id;
      logic [FieldPosWidth-1:0] position;
      logic [FieldPosWidth-1:0] count;
      logic                     is_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } fsm_type;

endpackage

// ===== hdl/jq_ram.sv =====
module jq_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/job_queue_keyed_removal.sv =====
// Ordered job queue with keyed search and removal.
// Request channel: drive req_data with a transaction and raise start while
// busy is low; the transaction is taken on that edge and busy rises the next
// cycle.
// Result channel: rsp_data is valid for exactly one cycle while rsp_valid is
// high; the receiver cannot stall, every result must be captured when shown.
// One result per request.
// Insert and rejected requests go straight to the result. Pop takes the
// front slot, find scans from the rear until a slot matches or none is
// left, keyed removal scans the same way; pop and removal then shift the
// entries behind the removed one forward. Scans and shifts read one slot
// at a time over the single read port of the slot memory.
// One request is in flight at a time; busy stays high through the result
// cycle, so the next start is taken only after the result cycle is over.
// Reset (synchronous, active high) empties the queue; slot contents are
// not cleared, as no slot is used before an insert has written it.
module job_queue_keyed_removal #(
   parameter int unsigned QUEUE_DEPTH = jq_pkg::QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  jq_pkg::req_type_s_type req_data,
   output logic                   rsp_valid,
   output jq_pkg::rsp_type        rsp_data
);
   import jq_pkg::*;

   localparam int unsigned AddrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

   fsm_type state_ff, state_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] idx_ff, idx_in;
   req_type_s_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   logic [SlotWidth-1:0] wr_data, rd_data;

   jq_ram #(.Width(SlotWidth), .Depth(1 << AddrWidth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic by_pid, hit, is_rm;
   assign by_pid = (req_ff.req_type == REQ_RM_PID) || (req_ff.req_type == REQ_FIND_PID);
   assign is_rm = (req_ff.req_type == REQ_RM_PID) || (req_ff.req_type == REQ_RM_JOB)
                  || (req_ff.req_type == REQ_POP);
   assign hit = by_pid ? (rd_data[PidWidth-1:0] == req_ff.proc_id)
                       : (rd_data[SlotWidth-1:PidWidth] == req_ff.job_number);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AddrWidth-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[AddrWidth-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in = req_data;
               rsp_in = '0;
               rsp_in.status = ST_OK;
               unique case (req_data.req_type) inside
                  REQ_INSERT: begin
                     if (count_ff >= CntWidth'(QUEUE_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AddrWidth-1:0];
                        wr_data  = {req_data.job_number, req_data.proc_id};
                        count_in = count_ff + 1'b1;
                        rsp_in.position = FieldPosWidth'(count_ff + 1'b1);
                     end
                     state_in = S_DONE;
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        idx_in   = '0;
                        rd_addr  = '0;
                        state_in = S_SCAN_CHK;
                     end
                  end
                  REQ_RM_JOB, REQ_RM_PID, REQ_FIND_JOB, REQ_FIND_PID: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_NOT_FOUND;
                        state_in = S_DONE;
                     end else begin
                        idx_in   = count_ff - 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (req_ff.req_type == REQ_POP || hit) begin
               rsp_in.out_job_number = rd_data[SlotWidth-1:PidWidth];
               rsp_in.out_proc_id    = rd_data[PidWidth-1:0];
               rsp_in.position       = FieldPosWidth'(idx_ff + 1'b1);
               if (is_rm) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else if (idx_ff == '0) begin
               rsp_in.status = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_addr  = AddrWidth'(idx_ff + 1'b1);
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_DONE: begin
            rsp_in.count    = FieldPosWidth'(count_ff);
            rsp_in.is_empty = (count_ff == '0);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(QUEUE_DEPTH)) else $error("count overflow");
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result held");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !start |=> $stable(count_ff)) else $error("count moved");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> busy) else $error("busy low");
endmodule
